### design/lcrs_pkg.sv
// ----------------------------------------------------------------------------
// lcrs_pkg
// Shared types and constants for the Life row stepper: row and result
// widths, rule counts, and the record that moves one result row down the
// pipeline.
// ----------------------------------------------------------------------------
package lcrs_pkg;

   localparam int ROW_BITS        = 64;
   localparam int ROW_NUM_BITS    = 6;
   localparam int POP_BITS        = 13;
   localparam int NBR_BITS        = 4;
   localparam int CHUNK_BITS      = 8;
   localparam int NUM_CHUNKS      = ROW_BITS / CHUNK_BITS;
   localparam int CHUNK_CNT_BITS  = $clog2(CHUNK_BITS + 1);
   localparam int ROW_CNT_BITS    = $clog2(ROW_BITS + 1);

   localparam int DEF_GRID_WIDTH  = 64;
   localparam int DEF_GRID_HEIGHT = 64;

   localparam logic [NBR_BITS-1:0] BIRTH_COUNT   = NBR_BITS'(3);
   localparam logic [NBR_BITS-1:0] SURVIVE_COUNT = NBR_BITS'(2);
   localparam logic [POP_BITS-1:0] POP_MAX       = {POP_BITS{1'b1}};

   typedef struct packed {
      logic [ROW_BITS-1:0]     cells;
      logic [ROW_NUM_BITS-1:0] row;
      logic                    last;
   } item_type;

endpackage

### design/life_generation_row_stepper_top.sv
// ----------------------------------------------------------------------------
// life_generation_row_stepper_top
// One Conway Life (B3/S23) generation, streamed one row per transaction.
// ----------------------------------------------------------------------------
// Rows of the current generation enter top to bottom, one per cycle while
// req_ready is high. Each row after the first returns the next generation
// of the row above it; the bottom row returns two results (its upper
// neighbor, then itself, flagged last) and so holds off further input
// while the second result is made, because both results go through the
// single bank of GRID_WIDTH cell lanes. Cells outside the grid are dead,
// columns at GRID_WIDTH and above are ignored and returned as zero.
// Results pass the lane-result, chunk-count and output registers;
// population_so_far counts the new generation and saturates at 8191.
// ----------------------------------------------------------------------------
module life_generation_row_stepper_top #(
   parameter int GRID_WIDTH  = lcrs_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = lcrs_pkg::DEF_GRID_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lcrs_pkg::ROW_BITS-1:0]     req_row_cells,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lcrs_pkg::ROW_BITS-1:0]     rsp_next_row_cells,
   output logic [lcrs_pkg::ROW_NUM_BITS-1:0] rsp_row_number,
   output logic [lcrs_pkg::POP_BITS-1:0]     rsp_population_so_far,
   output logic                              rsp_last_of_generation
);
   import lcrs_pkg::*;

   localparam int RW = $clog2(GRID_HEIGHT);
   localparam logic [RW-1:0] LAST_ROW = RW'(GRID_HEIGHT - 1);

   logic [GRID_WIDTH-1:0] row_above_ff, row_above_in;
   logic [GRID_WIDTH-1:0] row_middle_ff, row_middle_in;
   logic [RW-1:0]         rows_ff, rows_in;
   logic                  pass_ff, pass_in;

   logic                  s1_valid_ff, s1_valid_in;
   item_type              s1_item_ff, s1_item_in;

   logic                  merge_ready;
   logic                  s1_free;
   logic                  req_fire;
   logic                  gen_fire;

   logic [GRID_WIDTH-1:0] cur_row;
   logic [GRID_WIDTH-1:0] down_row;
   logic [GRID_WIDTH+1:0] up_pad, mid_pad, down_pad;
   logic [ROW_BITS-1:0]   next_cells;
   logic [RW-1:0]         row_idx;
   logic [RW+ROW_NUM_BITS-1:0] row_idx_ext;

   assign s1_free   = !s1_valid_ff || merge_ready;
   assign req_ready = !pass_ff && s1_free;
   assign req_fire  = req_valid && req_ready;
   // second pass of the bottom row runs from stored rows alone
   assign gen_fire  = (req_fire && (rows_ff != '0)) || (pass_ff && s1_free);

   assign cur_row  = req_row_cells[GRID_WIDTH-1:0];
   assign down_row = pass_ff ? '0 : cur_row;
   assign up_pad   = {1'b0, row_above_ff, 1'b0};
   assign mid_pad  = {1'b0, row_middle_ff, 1'b0};
   assign down_pad = {1'b0, down_row, 1'b0};

   for (genvar x = 0; x < ROW_BITS; x++) begin : g_lane
      if (x < GRID_WIDTH) begin : g_cell
         lcrs_cell_lane u_lane (
            .up         (up_pad[x+2:x]),
            .mid        (mid_pad[x+2:x]),
            .down       (down_pad[x+2:x]),
            .alive_next (next_cells[x])
         );
      end else begin : g_pad
         assign next_cells[x] = 1'b0;
      end
   end

   assign row_idx     = pass_ff ? rows_ff : rows_ff - RW'(1);
   assign row_idx_ext = {{ROW_NUM_BITS{1'b0}}, row_idx};

   always_comb begin
      s1_item_in.cells = next_cells;
      s1_item_in.row   = row_idx_ext[ROW_NUM_BITS-1:0];
      s1_item_in.last  = pass_ff;
      s1_valid_in      = gen_fire || (s1_valid_ff && !merge_ready);
   end

   always_comb begin
      row_above_in  = row_above_ff;
      row_middle_in = row_middle_ff;
      rows_in       = rows_ff;
      pass_in       = pass_ff;
      if (pass_ff) begin
         if (s1_free) begin
            row_above_in  = '0;
            row_middle_in = '0;
            rows_in       = '0;
            pass_in       = 1'b0;
         end
      end else if (req_fire) begin
         row_above_in  = row_middle_ff;
         row_middle_in = cur_row;
         if (rows_ff == LAST_ROW) begin
            pass_in = 1'b1;
         end else begin
            rows_in = rows_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_above_ff  <= '0;
         row_middle_ff <= '0;
         rows_ff       <= '0;
         pass_ff       <= 1'b0;
         s1_valid_ff   <= 1'b0;
      end else begin
         row_above_ff  <= row_above_in;
         row_middle_ff <= row_middle_in;
         rows_ff       <= rows_in;
         pass_ff       <= pass_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (gen_fire) begin
         s1_item_ff <= s1_item_in;
      end
   end

   lcrs_pop_merge u_merge (
      .clock                  (clock),
      .reset                  (reset),
      .in_valid               (s1_valid_ff),
      .in_ready               (merge_ready),
      .in_item                (s1_item_ff),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_next_row_cells     (rsp_next_row_cells),
      .rsp_row_number         (rsp_row_number),
      .rsp_population_so_far  (rsp_population_so_far),
      .rsp_last_of_generation (rsp_last_of_generation)
   );

endmodule

### design/lcrs_cell_lane.sv
// ----------------------------------------------------------------------------
// lcrs_cell_lane
// B3/S23 rule for one cell, from its 3x3 neighborhood (bit 1 is the
// center column of each row).
// ----------------------------------------------------------------------------
module lcrs_cell_lane (
   input  logic [2:0] up,
   input  logic [2:0] mid,
   input  logic [2:0] down,
   output logic       alive_next
);
   import lcrs_pkg::*;

   logic [NBR_BITS-1:0] nbr_count;

   assign nbr_count = NBR_BITS'(up[0]) + NBR_BITS'(up[1]) + NBR_BITS'(up[2])
                    + NBR_BITS'(mid[0]) + NBR_BITS'(mid[2])
                    + NBR_BITS'(down[0]) + NBR_BITS'(down[1]) + NBR_BITS'(down[2]);

   assign alive_next = (nbr_count == BIRTH_COUNT) ||
                       (mid[1] && (nbr_count == SURVIVE_COUNT));

endmodule

### design/lcrs_pop_merge.sv
// ----------------------------------------------------------------------------
// lcrs_pop_merge
// Merges the lane results: per-chunk popcounts in one stage, then the chunk
// sum, saturating running population and the output register.
// ----------------------------------------------------------------------------
module lcrs_pop_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  lcrs_pkg::item_type                  in_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lcrs_pkg::ROW_BITS-1:0]       rsp_next_row_cells,
   output logic [lcrs_pkg::ROW_NUM_BITS-1:0]   rsp_row_number,
   output logic [lcrs_pkg::POP_BITS-1:0]       rsp_population_so_far,
   output logic                                rsp_last_of_generation
);
   import lcrs_pkg::*;

   logic                      s2_valid_ff, s2_valid_in;
   item_type                  s2_item_ff;
   logic [CHUNK_CNT_BITS-1:0] s2_cnt_ff [NUM_CHUNKS];
   logic [CHUNK_CNT_BITS-1:0] s2_cnt_in [NUM_CHUNKS];

   logic                      out_valid_ff, out_valid_in;
   item_type                  out_item_ff;
   logic [POP_BITS-1:0]       out_pop_ff;
   logic [POP_BITS-1:0]       live_total_ff, live_total_in;

   logic                      out_free;
   logic                      s2_fire;
   logic [ROW_CNT_BITS-1:0]   row_count;
   logic [POP_BITS:0]         pop_sum;
   logic [POP_BITS-1:0]       pop_sat;

   assign out_free = !out_valid_ff || rsp_ready;
   assign s2_fire  = s2_valid_ff && out_free;
   assign in_ready = !s2_valid_ff || out_free;

   always_comb begin
      for (int c = 0; c < NUM_CHUNKS; c++) begin
         s2_cnt_in[c] = '0;
         for (int b = 0; b < CHUNK_BITS; b++) begin
            s2_cnt_in[c] = s2_cnt_in[c]
                         + CHUNK_CNT_BITS'(in_item.cells[c*CHUNK_BITS + b]);
         end
      end
   end

   always_comb begin
      row_count = '0;
      for (int c = 0; c < NUM_CHUNKS; c++) begin
         row_count = row_count + ROW_CNT_BITS'(s2_cnt_ff[c]);
      end
      pop_sum = {1'b0, live_total_ff} + (POP_BITS+1)'(row_count);
      pop_sat = pop_sum[POP_BITS] ? POP_MAX : pop_sum[POP_BITS-1:0];
   end

   always_comb begin
      s2_valid_in   = (in_valid && in_ready) || (s2_valid_ff && !out_free);
      out_valid_in  = s2_fire || (out_valid_ff && !rsp_ready);
      live_total_in = live_total_ff;
      if (s2_fire) begin
         // population restarts once the bottom row has gone by
         live_total_in = s2_item_ff.last ? '0 : pop_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         live_total_ff <= '0;
      end else begin
         s2_valid_ff   <= s2_valid_in;
         out_valid_ff  <= out_valid_in;
         live_total_ff <= live_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s2_item_ff <= in_item;
         s2_cnt_ff  <= s2_cnt_in;
      end
      if (s2_fire) begin
         out_item_ff <= s2_item_ff;
         out_pop_ff  <= pop_sat;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_next_row_cells     = out_item_ff.cells;
   assign rsp_row_number         = out_item_ff.row;
   assign rsp_population_so_far  = out_pop_ff;
   assign rsp_last_of_generation = out_item_ff.last;

endmodule
